FILE: hdl/gps_stream_type_sniffer_defines.svh
// Assertion macros used by the sniffer top level.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef GPS_STREAM_TYPE_SNIFFER_DEFINES_SVH
`define GPS_STREAM_TYPE_SNIFFER_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)
`endif

`endif

FILE: hdl/gss_pkg.sv
// Types and constants of the GPS stream type sniffer.
// Used by gss_matcher and gps_stream_type_sniffer; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gss_pkg;

  typedef logic [2:0]  match_state_t;
  typedef logic [1:0]  verdict_t;
  typedef logic [11:0] count_t;

  typedef struct packed {
    match_state_t next_state;
    verdict_t     verdict;
  } match_res_t;

  localparam logic [7:0] BYTE_DLE    = 8'h10;
  localparam logic [7:0] BYTE_ETX    = 8'h03;
  localparam logic [7:0] BYTE_CR     = 8'h0D;
  localparam logic [7:0] BYTE_LF     = 8'h0A;
  localparam logic [7:0] BYTE_DOLLAR = 8'h24;
  localparam logic [7:0] BYTE_G      = 8'h47;
  localparam logic [7:0] BYTE_P      = 8'h50;

  localparam match_state_t ST_IDLE = 3'd0;
  localparam match_state_t ST_B1   = 3'd1;
  localparam match_state_t ST_B2   = 3'd2;
  localparam match_state_t ST_N1   = 3'd3;
  localparam match_state_t ST_N2   = 3'd4;
  localparam match_state_t ST_N3   = 3'd5;
  localparam match_state_t ST_N4   = 3'd6;

  localparam verdict_t V_HUNT = 2'd0;
  localparam verdict_t V_BIN  = 2'd1;
  localparam verdict_t V_NMEA = 2'd2;
  localparam verdict_t V_TIME = 2'd3;

  localparam count_t BUDGET_RESET = 12'd600;
  localparam count_t COUNT_MAX    = 12'hFFF;

endpackage

`default_nettype wire

FILE: hdl/gss_matcher.sv
// Byte pattern matcher: one step of the binary / NMEA framing search.
// Purely combinational; depends on gss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gss_matcher (
  input  wire  gss_pkg::match_state_t state,
  input  wire  [7:0]                  rx_byte,
  output gss_pkg::match_res_t         res
);
  import gss_pkg::*;

  always_comb begin
    res.next_state = ST_IDLE;
    res.verdict    = V_HUNT;
    case (state)
      ST_B1: begin
        if (rx_byte == BYTE_ETX) res.next_state = ST_B2;
        else if (rx_byte == BYTE_CR) res.next_state = ST_N1;
      end
      ST_B2: begin
        if (rx_byte == BYTE_DLE) res.verdict = V_BIN;
        else if (rx_byte == BYTE_CR) res.next_state = ST_N1;
      end
      ST_N1: begin
        if (rx_byte == BYTE_DLE) res.next_state = ST_B1;
        else if (rx_byte == BYTE_LF) res.next_state = ST_N2;
      end
      ST_N2: begin
        if (rx_byte == BYTE_DLE) res.next_state = ST_B1;
        else if (rx_byte == BYTE_DOLLAR) res.next_state = ST_N3;
      end
      ST_N3: begin
        if (rx_byte == BYTE_DLE) res.next_state = ST_B1;
        else if (rx_byte inside {BYTE_G, BYTE_P}) res.next_state = ST_N4;
      end
      ST_N4: begin
        if (rx_byte == BYTE_DLE) res.next_state = ST_B1;
        else if (rx_byte inside {BYTE_G, BYTE_P}) res.verdict = V_NMEA;
      end
      default: begin
        if (rx_byte == BYTE_DLE) res.next_state = ST_B1;
        else if (rx_byte == BYTE_CR) res.next_state = ST_N1;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/gps_stream_type_sniffer.sv
// Top level of the GPS stream type sniffer: state, budget counter, output buffer.
// Depends on gss_pkg, gss_matcher and gps_stream_type_sniffer_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

// Takes one received serial byte per item and returns one verdict item per
// byte: 0 hunting, 1 binary DLE ETX DLE framing, 2 NMEA CR LF '$' plus two
// G/P letters, 3 byte budget used up. A verdict holds until a byte arrives
// with the restart flag (tuser) set, which clears the matcher, counter and
// verdict before that byte is examined. The budget register (reset 600) is
// written through cfg_wr_en / cfg_wr_data; the user must write it only while
// the block is idle, which the block does not enforce. The block sustains one
// item per cycle unless its two-entry output buffer is full, and that buffer
// keeps in_tready registered and independent of out_tready.
module gps_stream_type_sniffer (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_wr_en,
  input  wire  [11:0] cfg_wr_data,   // byte_budget
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,      // [7:0] rx_byte
  input  wire         in_tuser,      // [0] restart
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [7:0]  out_tdata      // [1:0] verdict, [7:2] zero
);
  import gss_pkg::*;

  `include "gps_stream_type_sniffer_defines.svh"

  count_t       budget_r;
  match_state_t state_r, state_nxt;
  count_t       seen_r, seen_nxt;
  verdict_t     held_r, held_nxt;

  verdict_t     out_r, skid_r;
  logic         out_valid_r, skid_valid_r;

  match_state_t state_eff;
  count_t       seen_eff;
  verdict_t     held_eff;
  match_res_t   mres;
  logic         in_accept, out_free;

  assign in_tready = !skid_valid_r;
  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign state_eff = in_tuser ? ST_IDLE : state_r;
  assign seen_eff  = in_tuser ? '0 : seen_r;
  assign held_eff  = in_tuser ? V_HUNT : held_r;

  gss_matcher u_matcher (
    .state   (state_eff),
    .rx_byte (in_tdata),
    .res     (mres)
  );

  always_comb begin
    state_nxt = state_eff;
    seen_nxt  = seen_eff;
    held_nxt  = held_eff;
    if (held_eff == V_HUNT) begin
      state_nxt = mres.next_state;
      seen_nxt  = (seen_eff == COUNT_MAX) ? seen_eff : seen_eff + 12'd1;
      if (mres.verdict != V_HUNT) held_nxt = mres.verdict;
      else if (seen_nxt >= budget_r) held_nxt = V_TIME;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r     <= BUDGET_RESET;
      state_r      <= ST_IDLE;
      seen_r       <= '0;
      held_r       <= V_HUNT;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) budget_r <= cfg_wr_data;
      if (in_accept) begin
        state_r <= state_nxt;
        seen_r  <= seen_nxt;
        held_r  <= held_nxt;
      end
      if (skid_valid_r) begin
        if (out_tready) begin
          out_r        <= skid_r;
          skid_valid_r <= 1'b0;
        end
      end else if (in_accept) begin
        if (out_free) begin
          out_r       <= held_nxt;
          out_valid_r <= 1'b1;
        end else begin
          skid_r       <= held_nxt;
          skid_valid_r <= 1'b1;
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_r};

  `ASSERT_CLK(a_skid_needs_out, skid_valid_r |-> out_valid_r, "skid full with output empty")
  `ASSERT_CLK(a_idle_holds, !in_accept |=> ($stable(seen_r) && $stable(held_r)),
              "state moved without an item")
  `ASSERT_CLK(a_verdict_sticks,
              (in_accept && !in_tuser && held_r != V_HUNT) |=> (held_r == $past(held_r)),
              "held verdict changed without restart")
  `ASSERT_NEVER(a_state_code, state_r > ST_N4, "matcher in unused code")

endmodule

`default_nettype wire
